// ===== rtl/core/sktab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_pkg
// Types and constants shared by the sorted key table search core.
// ----------------------------------------------------------------------------
package sktab_pkg;

	localparam int KEY_W = 64;
	localparam int POS_W = 11;
	localparam int ACT_W = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_PROBE,
		ST_COMPARE,
		ST_MATCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic append;
		logic refuse;
		logic clear;
		logic search_init;
		logic probe_rd;
		logic probe_step;
		logic final_rd;
		logic match_eval;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    empty;
		logic    full;
		logic    range_open;
		logic    out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sktab_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sktab_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sktab_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_ctrl
// Sequencer for append, clear and lower-bound search requests.
// ----------------------------------------------------------------------------
module sktab_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire sktab_pkg::stat_t stat,
	output sktab_pkg::cmd_t      cmd
);

	import sktab_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_DONE;
				case (stat.act)
					ACT_APPEND: begin
						if (stat.full) begin
							cmd.refuse = 1'b1;
						end else begin
							cmd.append = 1'b1;
						end
					end
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
					end
					ACT_SEARCH: begin
						if (!stat.empty) begin
							cmd.search_init = 1'b1;
							state_d         = ST_PROBE;
						end
					end
					default: begin
					end
				endcase
			end
			ST_PROBE: begin
				if (stat.range_open) begin
					cmd.probe_rd = 1'b1;
					state_d      = ST_COMPARE;
				end else begin
					cmd.final_rd = 1'b1;
					state_d      = ST_MATCH;
				end
			end
			ST_COMPARE: begin
				cmd.probe_step = 1'b1;
				state_d        = ST_PROBE;
			end
			ST_MATCH: begin
				cmd.match_eval = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded while output slot busy");

	a_compare_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPARE |-> $past(state_q) == ST_PROBE)
		else $error("compare without preceding probe read");

	a_no_append_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !stat.full)
		else $error("append issued into full table");

endmodule
`default_nettype wire

// ===== rtl/core/sktab_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sktab_dp
// Key store, entry count, search bounds and output register.
// ----------------------------------------------------------------------------
module sktab_dp #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [sktab_pkg::ACT_W-1:0] action,
	input  wire logic [sktab_pkg::KEY_W-1:0] key,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             found,
	output logic      [sktab_pkg::POS_W-1:0] position,
	output logic                             status,
	input  wire sktab_pkg::cmd_t             cmd,
	output sktab_pkg::stat_t                 stat
);

	import sktab_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	action_t          act_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    lo_q;
	logic [AW-1:0]    hi_q;
	logic             hit_q;
	logic             refused_q;
	logic             out_valid_q;
	logic             found_q;
	logic [POS_W-1:0] position_q;
	logic             status_q;

	logic [AW:0]         mid_sum;
	logic [AW-1:0]       mid;
	logic [AW-1:0]       raddr;
	logic [KEY_W-1:0]    rdata;
	logic [CW-1:0]       pos_sel;
	logic [CW+POS_W-1:0] pos_wide;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[AW:1];
	assign raddr   = cmd.final_rd ? lo_q : mid;

	sktab_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(cnt_q[AW-1:0]),
		.wdata(key_q),
		.re   (cmd.probe_rd | cmd.final_rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action_t'(action);
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			hit_q     <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				hit_q     <= 1'b0;
				refused_q <= 1'b0;
			end
			if (cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.refuse) begin
				refused_q <= 1'b1;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
			end
			if (cmd.search_init) begin
				lo_q <= '0;
				hi_q <= AW'(cnt_q - CW'(1));
			end
			if (cmd.probe_step) begin
				if (key_q <= rdata) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + AW'(1);
				end
			end
			if (cmd.match_eval) begin
				hit_q <= (rdata == key_q);
			end
		end
	end

	assign pos_sel  = hit_q ? CW'(lo_q) : cnt_q;
	assign pos_wide = {{POS_W{1'b0}}, pos_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q    <= hit_q;
			position_q <= pos_wide[POS_W-1:0];
			status_q   <= refused_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;
	assign status    = status_q;

	assign stat.act        = act_q;
	assign stat.empty      = (cnt_q == '0);
	assign stat.full       = (cnt_q == CW'(TABLE_DEPTH));
	assign stat.range_open = (lo_q < hi_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search bounds crossed");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == '0 || cnt_q == $past(cnt_q) + CW'(1))
		else $error("entry count changed by more than one");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_key_table_lower_bound_search_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_lower_bound_search_core
// Sorted 64-bit key table with append, clear and leftmost binary search.
// ----------------------------------------------------------------------------
// One request at a time. Append, clear and the unused action go from
// capture through dispatch to the done state. A search of a non-empty table
// runs a binary search in which each halving step costs one read
// of the key RAM and one compare, since the RAM has a registered read port,
// followed by one more read for the equality check. The next request is taken
// while a finished result still waits in the output register.
module sorted_key_table_lower_bound_search_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [sktab_pkg::ACT_W-1:0] action,
	input  wire logic [sktab_pkg::KEY_W-1:0] key,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             found,
	output logic      [sktab_pkg::POS_W-1:0] position,
	output logic                             status
);

	import sktab_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sktab_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	sktab_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.action   (action),
		.key      (key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found    (found),
		.position (position),
		.status   (status),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
`default_nettype wire

// ===== verif/sktab_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktab_search_checker
// Watches the request and result channels of the sorted key table core. It
// keeps its own copy of the key table, works out the response to every
// accepted request and compares each accepted result with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module sktab_search_checker #(
	parameter int DEPTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic [sktab_pkg::ACT_W-1:0] action,
	input  wire logic [sktab_pkg::KEY_W-1:0] key,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic                        found,
	input  wire logic [sktab_pkg::POS_W-1:0] position,
	input  wire logic                        status,
	output int                               errors,
	output int                               outstanding
);
	import sktab_pkg::*;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             status;
	} response_t;

	logic [KEY_W-1:0] key_table [DEPTH];
	int               fill = 0;
	int               fail_total = 0;
	response_t        expected_responses [$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic response_t predict_response(input action_t act,
			input logic [KEY_W-1:0] k);
		response_t r;
		int        lo;
		int        hi;
		int        mid;
		r = '0;
		case (act)
			ACT_APPEND: begin
				if (fill < DEPTH) begin
					key_table[fill] = k;
					fill++;
				end else begin
					r.status = 1'b1;
				end
				r.position = fill[POS_W-1:0];
			end
			ACT_CLEAR: begin
				fill = 0;
				r.position = '0;
			end
			ACT_SEARCH: begin
				r.position = fill[POS_W-1:0];
				if (fill > 0) begin
					lo = 0;
					hi = fill - 1;
					while (lo < hi) begin
						mid = (lo + hi) >> 1;
						if (k <= key_table[mid])
							hi = mid;
						else
							lo = mid + 1;
					end
					if (key_table[lo] == k) begin
						r.found = 1'b1;
						r.position = lo[POS_W-1:0];
					end
				end
			end
			default: begin
				r.position = fill[POS_W-1:0];
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		response_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					$error("result with no request waiting: found %0d position %0d status %0d",
						found, position, status);
					fail_total++;
				end else begin
					want = expected_responses.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, found);
						fail_total++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, actual %0d", want.position, position);
						fail_total++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_total++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_responses.push_back(predict_response(action_t'(action), key));
		end
		errors <= fail_total;
		outstanding <= expected_responses.size();
	end

endmodule

// ===== verif/tb_sorted_key_table_lower_bound_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table_lower_bound_search_core
// Drives appends, clears and lower-bound searches into the sorted key table
// core: a directed pass over key extremes, duplicates, unsorted content and
// the unused action, one pass that fills the table and overfills it, then
// random table loads with searches that hit, just miss or miss widely. Both
// channels idle at random; the checker beside the core gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_lower_bound_search_core;
	import sktab_pkg::*;

	localparam int TABLE_DEPTH   = 1024;
	localparam int ITEM_TARGET   = 1300;
	localparam int QUIET_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 40;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [ACT_W-1:0] action;
	logic [KEY_W-1:0] key;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	logic [POS_W-1:0] position;
	logic             status;
	int               errors;
	int               outstanding;
	logic             burst;
	int               stall_left = 0;
	int               quiet_cycles = 0;
	int               requests_sent = 0;
	logic [KEY_W-1:0] loaded_keys [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_key_table_lower_bound_search_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.key      (key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found    (found),
		.position (position),
		.status   (status)
	);

	sktab_search_checker #(
		.DEPTH(TABLE_DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.key        (key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.position   (position),
		.status     (status),
		.errors     (errors),
		.outstanding(outstanding)
	);

	// hold each result for a random number of cycles
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			stall_left = burst ? 0 : $urandom_range(0, 11);
		else if (stall_left > 0)
			stall_left--;
		out_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] next_sorted_key(input logic [KEY_W-1:0] prev,
			input int shift_min);
		logic [KEY_W-1:0] step;
		logic [KEY_W-1:0] nxt;
		if ($urandom_range(0, 3) == 0)
			return prev;
		step = rand_key() >> $urandom_range(shift_min, 63);
		nxt = prev + step;
		return (nxt < prev) ? '1 : nxt;
	endfunction

	function automatic logic [KEY_W-1:0] pick_search_key();
		int               sel;
		logic [KEY_W-1:0] base;
		sel = $urandom_range(0, 9);
		if (loaded_keys.size() == 0 || sel > 7)
			return rand_key() >> $urandom_range(0, 63);
		base = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
		if (sel < 5)
			return base;
		return (sel == 5) ? base + 1 : base - 1;
	endfunction

	task automatic send_request(input action_t act, input logic [KEY_W-1:0] k);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		do @(posedge clk); while (in_stall);
		if (act != ACT_NONE)
			requests_sent++;
		if (act == ACT_CLEAR)
			loaded_keys.delete();
		if (act == ACT_APPEND && loaded_keys.size() < TABLE_DEPTH)
			loaded_keys.push_back(k);
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic run_table_sequence(input bit sorted, input int n_keys,
			input int n_searches, input int shift_min);
		logic [KEY_W-1:0] k;
		send_request(ACT_CLEAR, rand_key());
		k = rand_key() >> $urandom_range(shift_min, 63);
		for (int i = 0; i < n_keys; i++) begin
			send_request(ACT_APPEND, k);
			k = sorted ? next_sorted_key(k, shift_min) : rand_key();
		end
		for (int i = 0; i < n_searches; i++)
			send_request(ACT_SEARCH, pick_search_key());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_APPEND;
		key = '0;
		out_stall = 1'b0;
		burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACT_SEARCH, '0);
		send_request(ACT_SEARCH, '1);
		send_request(ACT_NONE, '1);
		send_request(ACT_APPEND, '0);
		send_request(ACT_APPEND, '0);
		send_request(ACT_APPEND, 64'd5);
		send_request(ACT_APPEND, 64'h8000_0000_0000_0000);
		send_request(ACT_APPEND, '1);
		send_request(ACT_APPEND, '1);
		send_request(ACT_SEARCH, '0);
		send_request(ACT_SEARCH, 64'd5);
		send_request(ACT_SEARCH, '1);
		send_request(ACT_SEARCH, 64'd3);
		send_request(ACT_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(ACT_SEARCH, 64'h8000_0000_0000_0000);
		send_request(ACT_NONE, '0);
		send_request(ACT_CLEAR, '0);
		send_request(ACT_SEARCH, '0);
		send_request(ACT_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(ACT_APPEND, 64'h5555_5555_5555_5555);
		send_request(ACT_SEARCH, 64'h5555_5555_5555_5555);
		send_request(ACT_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(ACT_CLEAR, '1);

		// fill the table to the top, then push past it
		await_results();
		burst = 1'b0;
		run_table_sequence(1'b1, TABLE_DEPTH, 8, 12);
		send_request(ACT_APPEND, '1);
		send_request(ACT_APPEND, rand_key());
		send_request(ACT_SEARCH, loaded_keys[0]);
		send_request(ACT_SEARCH, loaded_keys[$]);
		send_request(ACT_SEARCH, loaded_keys[0] - 1);
		send_request(ACT_SEARCH, '1);
		send_request(ACT_NONE, rand_key());
		send_request(ACT_CLEAR, rand_key());
		await_results();

		while (requests_sent < ITEM_TARGET) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(4, 16))
						send_request(action_t'($urandom_range(0, 3)),
							rand_key() >> $urandom_range(0, 63));
				end
				1: begin
					run_table_sequence(1'b0, $urandom_range(1, 20), $urandom_range(1, 8), 0);
				end
				2: begin
					await_results();
					run_table_sequence(1'b1, $urandom_range(1, 8), 4, 0);
				end
				default: begin
					run_table_sequence(1'b1, $urandom_range(0, 40), $urandom_range(1, 12), 0);
				end
			endcase
		end

		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sktab_pkg.sv
rtl/core/sktab_ram.sv
rtl/core/sktab_ctrl.sv
rtl/core/sktab_dp.sv
rtl/core/sorted_key_table_lower_bound_search_core.sv
verif/sktab_search_checker.sv
verif/tb_sorted_key_table_lower_bound_search_core.sv
